>>> src/paft_pkg.sv
// ---------------------------------------------------------------------------
// paft_pkg: shared types and constants for the 2D point transform
// Transform kinds, register indexes, angle constants and the sine table
// generator used at elaboration.
// ---------------------------------------------------------------------------
`default_nettype none

package paft_pkg;

    localparam int ANGLE_BITS       = 9;
    localparam int SCALE_BITS       = 8;
    localparam int KIND_BITS        = 3;
    localparam int CFG_INDEX_BITS   = 3;
    localparam int NUM_TRIG_ENTRIES = 91;
    localparam int TRIG_IDX_BITS    = 7;

    // cycles from a register write until the derived coefficients are valid
    localparam int SETTLE_CYCLES = 4;
    localparam int SETTLE_BITS   = $clog2(SETTLE_CYCLES + 1);

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    localparam logic [ANGLE_BITS-1:0] DEG_90  = 9'd90;
    localparam logic [ANGLE_BITS-1:0] DEG_180 = 9'd180;
    localparam logic [ANGLE_BITS-1:0] DEG_270 = 9'd270;
    localparam logic [ANGLE_BITS-1:0] DEG_360 = 9'd360;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_TRANSLATE,
        KIND_SCALE,
        KIND_ROTATE,
        KIND_REFLECT_X,
        KIND_REFLECT_Y,
        KIND_REFLECT_ORIGIN,
        KIND_REFLECT_DIAG,
        KIND_REFLECT_ANTI
    } kind_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_KIND,
        REG_REF_X,
        REG_REF_Y,
        REG_SCALE_X,
        REG_SCALE_Y,
        REG_ANGLE
    } cfg_index_t;

    // sin(d degrees), d in 0..90, scaled by 2^frac; Taylor series in Q30
    function automatic logic [63:0] sin_q(input int unsigned d, input int unsigned frac);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        x    = (64'(d) * PI_Q30 + 64'd90) / 64'd180;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        term = ((term * x2) >> 30) / 64'd6;   sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;  sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;  sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;  sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd110; sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd156; sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd210; sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd272; sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd342; sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd420; sum = sum + $signed(term);
        if (sum < 64'sd0)
        begin
            sum = 64'sd0;
        end
        if (sum > (64'sd1 <<< 30))
        begin
            sum = 64'sd1 <<< 30;
        end
        return (64'(sum) + (64'd1 << (29 - frac))) >> (30 - frac);
    endfunction

endpackage

`default_nettype wire

>>> src/paft_point_if.sv
// ---------------------------------------------------------------------------
// paft_point_if: input point channel
// Valid/ready channel carrying one vertex per request.
// ---------------------------------------------------------------------------
`default_nettype none

interface paft_point_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;

    modport source (output valid, output point_x, output point_y, input ready);
    modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

`default_nettype wire

>>> src/paft_result_if.sv
// ---------------------------------------------------------------------------
// paft_result_if: output point channel
// Valid/ready channel carrying one transformed vertex and its clip flag.
// ---------------------------------------------------------------------------
`default_nettype none

interface paft_result_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic                         clipped;

    modport source (output valid, output out_x, output out_y, output clipped, input ready);
    modport sink   (input valid, input out_x, input out_y, input clipped, output ready);
endinterface

`default_nettype wire

>>> src/paft_cfg_if.sv
// ---------------------------------------------------------------------------
// paft_cfg_if: register write channel
// Valid/ready channel carrying a register index and write data.
// ---------------------------------------------------------------------------
`default_nettype none

interface paft_cfg_if
    import paft_pkg::*;
#(
    parameter int COORD_BITS = 16
);
    localparam int DATA_BITS = (COORD_BITS > ANGLE_BITS) ? COORD_BITS : ANGLE_BITS;

    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [DATA_BITS-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> src/point_affine_transform_2d_top.sv
// ---------------------------------------------------------------------------
// point_affine_transform_2d_top: streaming 2D homogeneous transform
//
// Channels (valid/ready, a request moves on an edge with both high):
//   point  - one vertex (point_x, point_y) per request.
//   result - transformed vertex (out_x, out_y) and clipped, one per point,
//            in arrival order.
//   cfg    - register writes (index, data); always ready, registered on the handshake edge.
//            Index 0 kind, 1 ref_x, 2 ref_y, 3 scale_x, 4 scale_y, 5 angle.
// Throughput: one point per cycle while result.ready is high and the
//   coefficients are settled. A point passes the capture, multiply, round,
//   sum and saturate registers in turn, held wherever the receiver stalls;
//   result.valid comes from the saturate register.
// After reset and after every register write, point.ready stays low until
//   the sine/cosine lookup and offset products settle.
// Reset restores kind translate, ref 0, scales 1, angle 0; the pipeline
//   empties and result.valid drops.
// A stalled receiver holds the result register; earlier stages keep
//   filling, so point.ready drops only once all five stages are full.
// ---------------------------------------------------------------------------
`default_nettype none

module point_affine_transform_2d_top
    import paft_pkg::*;
#(
    parameter int COORD_BITS     = 16,
    parameter int TRIG_FRAC_BITS = 14
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    paft_point_if.sink       point,
    paft_result_if.source    result,
    paft_cfg_if.sink         cfg
);

    localparam int CW = TRIG_FRAC_BITS + SCALE_BITS;   // Q-format matrix entry
    localparam int TW = COORD_BITS + 9;                // integer offset column

    localparam logic [COORD_BITS-1:0] OUT_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic [COORD_BITS-1:0] OUT_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    // linear part: out_x = x*ax + y*bx + tx, out_y = x*ay + y*by + ty
    logic signed [CW-1:0]    ax, bx, ay, by;
    logic signed [TW-1:0]    tx, ty;
    logic signed [COORD_BITS:0] tx_low;
    logic                    coef_ok;

    // register writes never back-pressure
    assign cfg.ready = 1'b1;

    paft_coef #(
        .COORD_BITS     (COORD_BITS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_coef (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg.valid),
        .cfg_index          (cfg.index),
        .cfg_data           (cfg.data),
        .ax                 (ax),
        .bx                 (bx),
        .ay                 (ay),
        .by                 (by),
        .tx_hi_unused_guard (tx_low),
        .tx                 (tx),
        .ty                 (ty),
        .coef_ok            (coef_ok)
    );

    paft_pipe #(
        .COORD_BITS     (COORD_BITS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_pipe (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (point.valid),
        .in_ready    (point.ready),
        .in_x        (point.point_x),
        .in_y        (point.point_y),
        .ax          (ax),
        .bx          (bx),
        .ay          (ay),
        .by          (by),
        .tx          (tx),
        .ty          (ty),
        .coef_ok     (coef_ok),
        .out_valid   (result.valid),
        .out_ready   (result.ready),
        .out_x       (result.out_x),
        .out_y       (result.out_y),
        .out_clipped (result.clipped)
    );

    // points are held off while coefficients are stale
    a_no_accept_unsettled: assert property (@(posedge clk) disable iff (!rst_n)
        point.valid && point.ready |-> coef_ok)
        else $error("point accepted with stale coefficients");

    // a register write closes the point channel on the next cycle
    a_write_holds_off: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.valid && cfg.ready |=> !point.ready)
        else $error("point channel open right after a register write");

    // a clipped result carries a rail value on at least one coordinate
    a_clip_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.clipped |->
            (result.out_x == OUT_MAX) || (result.out_x == OUT_MIN) ||
            (result.out_y == OUT_MAX) || (result.out_y == OUT_MIN))
        else $error("clip flag without a saturated coordinate");

    // offset low bits mirror the coefficient output
    a_offset_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        coef_ok |-> (tx_low == tx[COORD_BITS:0]))
        else $error("offset column mismatch");

endmodule

`default_nettype wire

>>> src/paft_trig.sv
// ---------------------------------------------------------------------------
// paft_trig: sine and cosine lookup
// Folds the angle into the first quadrant, then reads the constant table.
// Two register stages.
// ---------------------------------------------------------------------------
`default_nettype none

module paft_trig
    import paft_pkg::*;
#(
    parameter int TRIG_FRAC_BITS = 14
) (
    input  wire logic                           clk,
    input  wire logic [ANGLE_BITS-1:0]          angle,
    output logic signed [TRIG_FRAC_BITS+1:0]    sin_val,
    output logic signed [TRIG_FRAC_BITS+1:0]    cos_val
);

    localparam int TRW = TRIG_FRAC_BITS + 2;

    logic signed [TRW-1:0]     sin_tab [NUM_TRIG_ENTRIES];

    logic [ANGLE_BITS-1:0]     ang_mod;
    logic [ANGLE_BITS-1:0]     sin_idx_next;
    logic [ANGLE_BITS-1:0]     cos_idx_next;
    logic                      sin_neg_next;
    logic                      cos_neg_next;

    logic [TRIG_IDX_BITS-1:0]  sin_idx_reg;
    logic [TRIG_IDX_BITS-1:0]  cos_idx_reg;
    logic                      sin_neg_reg;
    logic                      cos_neg_reg;
    logic signed [TRW-1:0]     sin_reg;
    logic signed [TRW-1:0]     cos_reg;

    for (genvar i = 0; i < NUM_TRIG_ENTRIES; i++)
    begin : g_tab
        assign sin_tab[i] = TRW'(sin_q(i, TRIG_FRAC_BITS));
    end

    // quadrant folding; cos(d) = sin(90 - d)
    always_comb
    begin
        ang_mod = (angle >= DEG_360) ? angle - DEG_360 : angle;
        if (ang_mod <= DEG_90)
        begin
            sin_idx_next = ang_mod;
            cos_idx_next = DEG_90 - ang_mod;
            sin_neg_next = 1'b0;
            cos_neg_next = 1'b0;
        end
        else if (ang_mod <= DEG_180)
        begin
            sin_idx_next = DEG_180 - ang_mod;
            cos_idx_next = ang_mod - DEG_90;
            sin_neg_next = 1'b0;
            cos_neg_next = 1'b1;
        end
        else if (ang_mod <= DEG_270)
        begin
            sin_idx_next = ang_mod - DEG_180;
            cos_idx_next = DEG_270 - ang_mod;
            sin_neg_next = 1'b1;
            cos_neg_next = 1'b1;
        end
        else
        begin
            sin_idx_next = DEG_360 - ang_mod;
            cos_idx_next = ang_mod - DEG_270;
            sin_neg_next = 1'b1;
            cos_neg_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        sin_idx_reg <= sin_idx_next[TRIG_IDX_BITS-1:0];
        cos_idx_reg <= cos_idx_next[TRIG_IDX_BITS-1:0];
        sin_neg_reg <= sin_neg_next;
        cos_neg_reg <= cos_neg_next;
        sin_reg     <= sin_neg_reg ? -sin_tab[sin_idx_reg] : sin_tab[sin_idx_reg];
        cos_reg     <= cos_neg_reg ? -sin_tab[cos_idx_reg] : sin_tab[cos_idx_reg];
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

`default_nettype wire

>>> src/paft_coef.sv
// ---------------------------------------------------------------------------
// paft_coef: configuration registers and matrix coefficients
// Holds the registers and derives the linear terms (Q fraction) and the
// constant offsets (integer) of both output columns.
// ---------------------------------------------------------------------------
`default_nettype none

module paft_coef
    import paft_pkg::*;
#(
    parameter int COORD_BITS     = 16,
    parameter int TRIG_FRAC_BITS = 14
) (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire logic                                        cfg_valid,
    input  wire logic [CFG_INDEX_BITS-1:0]                   cfg_index,
    input  wire logic [((COORD_BITS > ANGLE_BITS) ? COORD_BITS : ANGLE_BITS)-1:0] cfg_data,
    output logic signed [TRIG_FRAC_BITS+SCALE_BITS-1:0]      ax,
    output logic signed [TRIG_FRAC_BITS+SCALE_BITS-1:0]      bx,
    output logic signed [TRIG_FRAC_BITS+SCALE_BITS-1:0]      ay,
    output logic signed [TRIG_FRAC_BITS+SCALE_BITS-1:0]      by,
    output logic signed [COORD_BITS:0]                       tx_hi_unused_guard,
    output logic signed [COORD_BITS+8:0]                     tx,
    output logic signed [COORD_BITS+8:0]                     ty,
    output logic                                             coef_ok
);

    localparam int F   = TRIG_FRAC_BITS;
    localparam int CW  = F + SCALE_BITS;
    localparam int TW  = COORD_BITS + 9;
    localparam int TRW = F + 2;
    localparam int OMW = F + 3;
    localparam int RPW = COORD_BITS + F + 3;
    localparam int RSW = RPW + 1;
    localparam int SCW = SCALE_BITS + 1;

    localparam logic signed [CW-1:0]  COEF_ONE  = {{(CW-F-1){1'b0}}, 1'b1, {F{1'b0}}};
    localparam logic signed [CW-1:0]  COEF_ZERO = '0;
    localparam logic signed [OMW-1:0] ONE_W     = {2'b00, 1'b1, {F{1'b0}}};
    localparam logic signed [RSW-1:0] HALF_R    = {{(RSW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
    localparam logic signed [SCW-1:0] ONE_S     = {{(SCW-1){1'b0}}, 1'b1};

    kind_t                          kind_reg;
    logic signed [COORD_BITS-1:0]   ref_x_reg;
    logic signed [COORD_BITS-1:0]   ref_y_reg;
    logic signed [SCALE_BITS-1:0]   scale_x_reg;
    logic signed [SCALE_BITS-1:0]   scale_y_reg;
    logic [ANGLE_BITS-1:0]          angle_reg;
    logic [SETTLE_BITS-1:0]         settle_reg;

    logic signed [TRW-1:0]          sin_val;
    logic signed [TRW-1:0]          cos_val;
    logic signed [OMW-1:0]          one_minus_c;
    logic signed [SCW-1:0]          one_minus_sx;
    logic signed [SCW-1:0]          one_minus_sy;

    logic signed [RPW-1:0]          p_rx_omc_reg;
    logic signed [RPW-1:0]          p_ry_s_reg;
    logic signed [RPW-1:0]          p_ry_omc_reg;
    logic signed [RPW-1:0]          p_rx_s_reg;
    logic signed [TW-1:0]           p_rx_sc_reg;
    logic signed [TW-1:0]           p_ry_sc_reg;
    logic signed [CW-1:0]           ax_reg;
    logic signed [CW-1:0]           bx_reg;
    logic signed [CW-1:0]           ay_reg;
    logic signed [CW-1:0]           by_reg;

    logic signed [RSW-1:0]          rot_x_sum;
    logic signed [RSW-1:0]          rot_y_sum;
    logic signed [RSW-1:0]          rot_x_sh;
    logic signed [RSW-1:0]          rot_y_sh;
    logic signed [TW-1:0]           tx_next;
    logic signed [TW-1:0]           ty_next;
    logic signed [TW-1:0]           tx_reg;
    logic signed [TW-1:0]           ty_reg;

    // register file and settle counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg    <= KIND_TRANSLATE;
            ref_x_reg   <= '0;
            ref_y_reg   <= '0;
            scale_x_reg <= SCALE_BITS'(1);
            scale_y_reg <= SCALE_BITS'(1);
            angle_reg   <= '0;
            settle_reg  <= SETTLE_BITS'(SETTLE_CYCLES);
        end
        else
        begin
            if (cfg_valid)
            begin
                settle_reg <= SETTLE_BITS'(SETTLE_CYCLES);
                unique case (cfg_index_t'(cfg_index))
                    REG_KIND:    kind_reg    <= kind_t'(cfg_data[KIND_BITS-1:0]);
                    REG_REF_X:   ref_x_reg   <= cfg_data[COORD_BITS-1:0];
                    REG_REF_Y:   ref_y_reg   <= cfg_data[COORD_BITS-1:0];
                    REG_SCALE_X: scale_x_reg <= cfg_data[SCALE_BITS-1:0];
                    REG_SCALE_Y: scale_y_reg <= cfg_data[SCALE_BITS-1:0];
                    REG_ANGLE:   angle_reg   <= cfg_data[ANGLE_BITS-1:0];
                    default:     ;
                endcase
            end
            else if (settle_reg != '0)
            begin
                settle_reg <= settle_reg - SETTLE_BITS'(1);
            end
        end
    end

    paft_trig #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_trig (
        .clk     (clk),
        .angle   (angle_reg),
        .sin_val (sin_val),
        .cos_val (cos_val)
    );

    assign one_minus_c  = ONE_W - OMW'(cos_val);
    assign one_minus_sx = ONE_S - SCW'(scale_x_reg);
    assign one_minus_sy = ONE_S - SCW'(scale_y_reg);

    // products of the offsets, and the linear coefficients per kind
    always_ff @(posedge clk)
    begin
        p_rx_omc_reg <= RPW'(ref_x_reg) * RPW'(one_minus_c);
        p_ry_s_reg   <= RPW'(ref_y_reg) * RPW'(sin_val);
        p_ry_omc_reg <= RPW'(ref_y_reg) * RPW'(one_minus_c);
        p_rx_s_reg   <= RPW'(ref_x_reg) * RPW'(sin_val);
        p_rx_sc_reg  <= TW'(ref_x_reg) * TW'(one_minus_sx);
        p_ry_sc_reg  <= TW'(ref_y_reg) * TW'(one_minus_sy);

        unique case (kind_reg)
            KIND_TRANSLATE:
            begin
                ax_reg <= COEF_ONE;  bx_reg <= COEF_ZERO;
                ay_reg <= COEF_ZERO; by_reg <= COEF_ONE;
            end
            KIND_SCALE:
            begin
                ax_reg <= {scale_x_reg, {F{1'b0}}}; bx_reg <= COEF_ZERO;
                ay_reg <= COEF_ZERO;                by_reg <= {scale_y_reg, {F{1'b0}}};
            end
            KIND_ROTATE:
            begin
                ax_reg <= CW'(cos_val);  bx_reg <= -CW'(sin_val);
                ay_reg <= CW'(sin_val);  by_reg <= CW'(cos_val);
            end
            KIND_REFLECT_X:
            begin
                ax_reg <= COEF_ONE;  bx_reg <= COEF_ZERO;
                ay_reg <= COEF_ZERO; by_reg <= -COEF_ONE;
            end
            KIND_REFLECT_Y:
            begin
                ax_reg <= -COEF_ONE; bx_reg <= COEF_ZERO;
                ay_reg <= COEF_ZERO; by_reg <= COEF_ONE;
            end
            KIND_REFLECT_ORIGIN:
            begin
                ax_reg <= -COEF_ONE; bx_reg <= COEF_ZERO;
                ay_reg <= COEF_ZERO; by_reg <= -COEF_ONE;
            end
            KIND_REFLECT_DIAG:
            begin
                ax_reg <= COEF_ZERO; bx_reg <= COEF_ONE;
                ay_reg <= COEF_ONE;  by_reg <= COEF_ZERO;
            end
            KIND_REFLECT_ANTI:
            begin
                ax_reg <= COEF_ZERO; bx_reg <= -COEF_ONE;
                ay_reg <= -COEF_ONE; by_reg <= COEF_ZERO;
            end
        endcase
    end

    // offset column per kind; the rotation pivot offset is rounded half up once
    always_comb
    begin
        rot_x_sum = RSW'(p_rx_omc_reg) + RSW'(p_ry_s_reg) + HALF_R;
        rot_y_sum = RSW'(p_ry_omc_reg) - RSW'(p_rx_s_reg) + HALF_R;
        rot_x_sh  = rot_x_sum >>> F;
        rot_y_sh  = rot_y_sum >>> F;
        unique case (kind_reg)
            KIND_TRANSLATE:
            begin
                tx_next = TW'(ref_x_reg);
                ty_next = TW'(ref_y_reg);
            end
            KIND_SCALE:
            begin
                tx_next = p_rx_sc_reg;
                ty_next = p_ry_sc_reg;
            end
            KIND_ROTATE:
            begin
                tx_next = rot_x_sh[TW-1:0];
                ty_next = rot_y_sh[TW-1:0];
            end
            default:
            begin
                tx_next = '0;
                ty_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        tx_reg <= tx_next;
        ty_reg <= ty_next;
    end

    assign ax      = ax_reg;
    assign bx      = bx_reg;
    assign ay      = ay_reg;
    assign by      = by_reg;
    assign tx      = tx_reg;
    assign ty      = ty_reg;
    assign tx_hi_unused_guard = tx_reg[COORD_BITS:0];
    assign coef_ok = (settle_reg == '0);

endmodule

`default_nettype wire

>>> src/paft_pipe.sv
// ---------------------------------------------------------------------------
// paft_pipe: point datapath
// Five stages: capture, multiply, round, sum, saturate. Per-stage valid
// bits; a stage advances when the one after it is empty or advancing.
// ---------------------------------------------------------------------------
`default_nettype none

module paft_pipe
    import paft_pkg::*;
#(
    parameter int COORD_BITS     = 16,
    parameter int TRIG_FRAC_BITS = 14
) (
    input  wire logic                                           clk,
    input  wire logic                                           rst_n,
    input  wire logic                                           in_valid,
    output logic                                                in_ready,
    input  wire logic signed [COORD_BITS-1:0]                   in_x,
    input  wire logic signed [COORD_BITS-1:0]                   in_y,
    input  wire logic signed [TRIG_FRAC_BITS+SCALE_BITS-1:0]    ax,
    input  wire logic signed [TRIG_FRAC_BITS+SCALE_BITS-1:0]    bx,
    input  wire logic signed [TRIG_FRAC_BITS+SCALE_BITS-1:0]    ay,
    input  wire logic signed [TRIG_FRAC_BITS+SCALE_BITS-1:0]    by,
    input  wire logic signed [COORD_BITS+8:0]                   tx,
    input  wire logic signed [COORD_BITS+8:0]                   ty,
    input  wire logic                                           coef_ok,
    output logic                                                out_valid,
    input  wire logic                                           out_ready,
    output logic signed [COORD_BITS-1:0]                        out_x,
    output logic signed [COORD_BITS-1:0]                        out_y,
    output logic                                                out_clipped
);

    localparam int F  = TRIG_FRAC_BITS;
    localparam int CW = F + SCALE_BITS;
    localparam int PW = COORD_BITS + CW;
    localparam int TW = COORD_BITS + 9;
    localparam int SW = TW + 2;

    localparam logic signed [PW:0]   HALF_P  = {{(PW+1-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
    localparam logic signed [SW-1:0] SAT_HI  = {{(SW-COORD_BITS+1){1'b0}},
                                                {(COORD_BITS-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO  = {{(SW-COORD_BITS+1){1'b1}},
                                                {(COORD_BITS-1){1'b0}}};
    localparam logic signed [COORD_BITS-1:0] OUT_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] OUT_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic                          v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic                          rdy1, rdy2, rdy3, rdy4, rdy5;
    logic                          accept;

    logic signed [COORD_BITS-1:0]  x1_reg, y1_reg;
    logic signed [PW-1:0]          pxa_reg, pyb_reg, pxc_reg, pyd_reg;
    logic signed [PW:0]            rxa_sum, ryb_sum, rxc_sum, ryd_sum;
    logic signed [PW:0]            rxa_sh, ryb_sh, rxc_sh, ryd_sh;
    logic signed [TW-1:0]          rxa_reg, ryb_reg, rxc_reg, ryd_reg;
    logic signed [SW-1:0]          sum_x_reg, sum_y_reg;
    logic signed [COORD_BITS-1:0]  out_x_next, out_y_next;
    logic                          clip_x, clip_y;
    logic signed [COORD_BITS-1:0]  out_x_reg, out_y_reg;
    logic                          clip_reg;

    assign rdy5     = !v5_reg || out_ready;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1 && coef_ok;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= accept;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // round half up: floor(p / 2^F + 1/2)
    always_comb
    begin
        rxa_sum = (PW+1)'(pxa_reg) + HALF_P;
        ryb_sum = (PW+1)'(pyb_reg) + HALF_P;
        rxc_sum = (PW+1)'(pxc_reg) + HALF_P;
        ryd_sum = (PW+1)'(pyd_reg) + HALF_P;
        rxa_sh  = rxa_sum >>> F;
        ryb_sh  = ryb_sum >>> F;
        rxc_sh  = rxc_sum >>> F;
        ryd_sh  = ryd_sum >>> F;
    end

    always_comb
    begin
        clip_x     = 1'b0;
        clip_y     = 1'b0;
        out_x_next = sum_x_reg[COORD_BITS-1:0];
        out_y_next = sum_y_reg[COORD_BITS-1:0];
        if (sum_x_reg > SAT_HI)
        begin
            out_x_next = OUT_MAX;
            clip_x     = 1'b1;
        end
        else if (sum_x_reg < SAT_LO)
        begin
            out_x_next = OUT_MIN;
            clip_x     = 1'b1;
        end
        if (sum_y_reg > SAT_HI)
        begin
            out_y_next = OUT_MAX;
            clip_y     = 1'b1;
        end
        else if (sum_y_reg < SAT_LO)
        begin
            out_y_next = OUT_MIN;
            clip_y     = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            x1_reg <= in_x;
            y1_reg <= in_y;
        end
        if (rdy2)
        begin
            pxa_reg <= PW'(x1_reg) * PW'(ax);
            pyb_reg <= PW'(y1_reg) * PW'(bx);
            pxc_reg <= PW'(x1_reg) * PW'(ay);
            pyd_reg <= PW'(y1_reg) * PW'(by);
        end
        if (rdy3)
        begin
            rxa_reg <= rxa_sh[TW-1:0];
            ryb_reg <= ryb_sh[TW-1:0];
            rxc_reg <= rxc_sh[TW-1:0];
            ryd_reg <= ryd_sh[TW-1:0];
        end
        if (rdy4)
        begin
            sum_x_reg <= SW'(rxa_reg) + SW'(ryb_reg) + SW'(tx);
            sum_y_reg <= SW'(rxc_reg) + SW'(ryd_reg) + SW'(ty);
        end
        if (rdy5)
        begin
            out_x_reg <= out_x_next;
            out_y_reg <= out_y_next;
            clip_reg  <= clip_x || clip_y;
        end
    end

    assign out_valid   = v5_reg;
    assign out_x       = out_x_reg;
    assign out_y       = out_y_reg;
    assign out_clipped = clip_reg;

endmodule

`default_nettype wire

>>> bench/paft_result_checker.sv
// ---------------------------------------------------------------------------
// paft_result_checker: result predictor and comparator for the 2D transform
// Watches the register, point and result channels, keeps its own copy of the
// registers, predicts one transformed vertex per accepted point and compares
// every accepted result against the oldest prediction.
// ---------------------------------------------------------------------------
`default_nettype none

module paft_result_checker
    import paft_pkg::*;
#(
    parameter int COORD_BITS     = 16,
    parameter int TRIG_FRAC_BITS = 14
) (
    input  wire logic clk,
    input  wire logic rst_n,
    paft_point_if     point,
    paft_result_if    result,
    paft_cfg_if       cfg,
    output int        points_in_flight,
    output int        mismatch_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned PI_IN_Q30 = 64'd3373259426;
    localparam longint COORD_MAX = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    localparam longint COORD_MIN = -(longint'(1) <<< (COORD_BITS - 1));
    localparam longint TRIG_ONE  = longint'(1) <<< TRIG_FRAC_BITS;
    localparam int QUARTER_TURN  = 90;
    localparam int HALF_TURN     = 180;
    localparam int THREE_QUARTER = 270;
    localparam int FULL_TURN     = 360;
    localparam int SERIES_TERMS  = 10;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic                         clipped;
    } vertex_t;

    // shadow registers
    kind_t                        kind_q;
    logic signed [COORD_BITS-1:0] ref_x_q;
    logic signed [COORD_BITS-1:0] ref_y_q;
    logic signed [SCALE_BITS-1:0] scale_x_q;
    logic signed [SCALE_BITS-1:0] scale_y_q;
    logic [ANGLE_BITS-1:0]        angle_q;

    longint  sine_tab [0:QUARTER_TURN];
    vertex_t predicted_points [$];

    // sin(deg) * 2^F, deg in 0..90, Taylor series in unsigned Q30
    function automatic longint taylor_sine(input int unsigned deg);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        x    = (longint'(deg) * PI_IN_Q30 + 64'd90) / 64'd180;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int k = 1; k <= SERIES_TERMS; k++)
        begin
            term = ((term * x2) >> 30) / 64'(2 * k * (2 * k + 1));
            if (k % 2 == 1)
            begin
                sum -= longint'(term);
            end
            else
            begin
                sum += longint'(term);
            end
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        if (sum > (longint'(1) <<< 30))
        begin
            sum = longint'(1) <<< 30;
        end
        return (sum + (longint'(1) <<< (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
    endfunction

    // floor(p / 2^F + 1/2)
    function automatic longint round_half_up(input longint p);
        return (p + (longint'(1) <<< (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
    endfunction

    function automatic longint clamp_coord(input longint v);
        if (v > COORD_MAX)
        begin
            return COORD_MAX;
        end
        if (v < COORD_MIN)
        begin
            return COORD_MIN;
        end
        return v;
    endfunction

    function automatic vertex_t transform_point(input logic signed [COORD_BITS-1:0] px,
                                                input logic signed [COORD_BITS-1:0] py);
        longint      x;
        longint      y;
        longint      rx;
        longint      ry;
        longint      sx;
        longint      sy;
        longint      ox;
        longint      oy;
        longint      s;
        longint      c;
        longint      ox_sat;
        longint      oy_sat;
        int unsigned d;
        vertex_t     v;
        x  = px;
        y  = py;
        rx = ref_x_q;
        ry = ref_y_q;
        sx = scale_x_q;
        sy = scale_y_q;
        case (kind_q)
            KIND_TRANSLATE:
            begin
                ox = x + rx;
                oy = y + ry;
            end
            KIND_SCALE:
            begin
                ox = x * sx + rx * (1 - sx);
                oy = y * sy + ry * (1 - sy);
            end
            KIND_ROTATE:
            begin
                d = int'(angle_q) % FULL_TURN;
                // quadrant folding onto the 0..90 table
                if (d <= QUARTER_TURN)
                begin
                    s = sine_tab[d];
                    c = sine_tab[QUARTER_TURN - d];
                end
                else if (d <= HALF_TURN)
                begin
                    s = sine_tab[HALF_TURN - d];
                    c = -sine_tab[d - QUARTER_TURN];
                end
                else if (d <= THREE_QUARTER)
                begin
                    s = -sine_tab[d - HALF_TURN];
                    c = -sine_tab[THREE_QUARTER - d];
                end
                else
                begin
                    s = -sine_tab[FULL_TURN - d];
                    c = sine_tab[d - THREE_QUARTER];
                end
                ox = round_half_up(x * c) + round_half_up(-y * s)
                   + round_half_up(rx * (TRIG_ONE - c) + ry * s);
                oy = round_half_up(x * s) + round_half_up(y * c)
                   + round_half_up(ry * (TRIG_ONE - c) - rx * s);
            end
            KIND_REFLECT_X:
            begin
                ox = x;
                oy = -y;
            end
            KIND_REFLECT_Y:
            begin
                ox = -x;
                oy = y;
            end
            KIND_REFLECT_ORIGIN:
            begin
                ox = -x;
                oy = -y;
            end
            KIND_REFLECT_DIAG:
            begin
                ox = y;
                oy = x;
            end
            default:
            begin
                ox = -y;
                oy = -x;
            end
        endcase
        ox_sat    = clamp_coord(ox);
        oy_sat    = clamp_coord(oy);
        v.x       = ox_sat[COORD_BITS-1:0];
        v.y       = oy_sat[COORD_BITS-1:0];
        v.clipped = (ox_sat != ox) || (oy_sat != oy);
        return v;
    endfunction

    initial
    begin
        for (int d = 0; d <= QUARTER_TURN; d++)
        begin
            sine_tab[d] = taylor_sine(d);
        end
    end

    always @(posedge clk)
    begin : monitor
        vertex_t want;
        if (!rst_n)
        begin
            kind_q    = KIND_TRANSLATE;
            ref_x_q   = '0;
            ref_y_q   = '0;
            scale_x_q = 1;
            scale_y_q = 1;
            angle_q   = '0;
            predicted_points.delete();
            mismatch_count = 0;
            points_in_flight <= 0;
        end
        else
        begin
            // writes only land while idle, so order against points is moot
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_KIND:    kind_q    = kind_t'(cfg.data[KIND_BITS-1:0]);
                    REG_REF_X:   ref_x_q   = cfg.data[COORD_BITS-1:0];
                    REG_REF_Y:   ref_y_q   = cfg.data[COORD_BITS-1:0];
                    REG_SCALE_X: scale_x_q = cfg.data[SCALE_BITS-1:0];
                    REG_SCALE_Y: scale_y_q = cfg.data[SCALE_BITS-1:0];
                    REG_ANGLE:   angle_q   = cfg.data[ANGLE_BITS-1:0];
                    default: ;
                endcase
            end
            if (point.valid && point.ready)
            begin
                predicted_points.push_back(transform_point(point.point_x, point.point_y));
            end
            if (result.valid && result.ready)
            begin
                if (predicted_points.size() == 0)
                begin
                    $display("%0t ns: result with no request pending, actual (%0d, %0d, %0b)",
                             $time, result.out_x, result.out_y, result.clipped);
                    mismatch_count++;
                end
                else
                begin
                    want = predicted_points.pop_front();
                    if (result.out_x !== want.x)
                    begin
                        $display("%0t ns: out_x mismatch, expected %0d, actual %0d",
                                 $time, want.x, result.out_x);
                        mismatch_count++;
                    end
                    if (result.out_y !== want.y)
                    begin
                        $display("%0t ns: out_y mismatch, expected %0d, actual %0d",
                                 $time, want.y, result.out_y);
                        mismatch_count++;
                    end
                    if (result.clipped !== want.clipped)
                    begin
                        $display("%0t ns: clipped mismatch, expected %0b, actual %0b",
                                 $time, want.clipped, result.clipped);
                        mismatch_count++;
                    end
                end
            end
            points_in_flight <= predicted_points.size();
        end
    end

endmodule

`default_nettype wire

>>> bench/tb_point_affine_transform_2d_top.sv
// ---------------------------------------------------------------------------
// tb_point_affine_transform_2d_top: testbench for the 2D point transform
// Drives points and register writes, stalls the result side at random and
// leaves prediction and comparison to the result checker. A directed pass
// covers every transform kind and the saturation corners; random phases
// then reprogram the registers and stream points with random gaps.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_point_affine_transform_2d_top
    import paft_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS        = 16;
    localparam int TRIG_FRAC_BITS    = 14;
    localparam int NUM_RANDOM_POINTS = 1300;
    localparam int DRAIN_CYCLES      = 12;     // pipeline depth plus margin
    localparam int TIMEOUT_NS        = 4_000_000;
    localparam int DATA_BITS         = (COORD_BITS > ANGLE_BITS) ? COORD_BITS : ANGLE_BITS;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    paft_point_if  #(.COORD_BITS(COORD_BITS)) point_ch ();
    paft_result_if #(.COORD_BITS(COORD_BITS)) result_ch ();
    paft_cfg_if    #(.COORD_BITS(COORD_BITS)) cfg_ch ();

    int points_in_flight;
    int mismatch_count;
    int points_sent = 0;

    // per-phase idle switches; off gives back-to-back stretches
    bit src_idle_on  = 1'b0;
    bit sink_idle_on = 1'b0;

    point_affine_transform_2d_top #(
        .COORD_BITS     (COORD_BITS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .point  (point_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    paft_result_checker #(
        .COORD_BITS     (COORD_BITS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) i_result_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .point            (point_ch),
        .result           (result_ch),
        .cfg              (cfg_ch),
        .points_in_flight (points_in_flight),
        .mismatch_count   (mismatch_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Gap length: mostly none, often a few cycles, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 25);
    endfunction

    // Coordinates: corners, a small window around the origin (keeps scale and
    // rotate results mostly unsaturated), or anything in the full range.
    function automatic logic [COORD_BITS-1:0] rand_coord();
        int r;
        int v;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            case ($urandom_range(0, 3))
                0:       v = -32768;
                1:       v = 32767;
                2:       v = -1;
                default: v = 0;
            endcase
        end
        else if (r < 5)
        begin
            v = int'($urandom_range(0, 1200)) - 600;
        end
        else
        begin
            v = $urandom;
        end
        return v[COORD_BITS-1:0];
    endfunction

    function automatic logic [DATA_BITS-1:0] rand_ref();
        int r;
        int v;
        r = $urandom_range(0, 7);
        if (r == 0)
        begin
            v = ($urandom_range(0, 1) == 0) ? -32768 : 32767;
        end
        else if (r < 4)
        begin
            v = int'($urandom_range(0, 1200)) - 600;
        end
        else
        begin
            v = $urandom;
        end
        return v[DATA_BITS-1:0];
    endfunction

    // Scale: mostly the documented -64..64, sometimes the 8-bit corners or
    // raw bits, which also sets the unused upper data bits.
    function automatic logic [DATA_BITS-1:0] rand_scale();
        int r;
        int v;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            v = $urandom;
        end
        else if (r == 1)
        begin
            case ($urandom_range(0, 3))
                0:       v = -128;
                1:       v = 127;
                2:       v = -64;
                default: v = 64;
            endcase
        end
        else
        begin
            v = int'($urandom_range(0, 128)) - 64;
        end
        return v[DATA_BITS-1:0];
    endfunction

    // Angle: whole circle, quadrant edges, beyond 359, or raw data bits.
    function automatic logic [DATA_BITS-1:0] rand_angle();
        int r;
        int v;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            v = $urandom_range(360, 511);
        end
        else if (r == 1)
        begin
            v = ($urandom_range(0, 4) == 4) ? 359 : 90 * $urandom_range(0, 3);
        end
        else if (r == 2)
        begin
            v = $urandom;
        end
        else
        begin
            v = $urandom_range(0, 359);
        end
        return v[DATA_BITS-1:0];
    endfunction

    // One register write; valid drops on the cycle after the handshake.
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [DATA_BITS-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // One point request. Valid stays high when no gap follows so that the
    // next call can present its data on the very next edge.
    task automatic send_point(input logic [COORD_BITS-1:0] px,
                              input logic [COORD_BITS-1:0] py);
        int gap;
        point_ch.valid   <= 1'b1;
        point_ch.point_x <= px;
        point_ch.point_y <= py;
        do
            @(posedge clk);
        while (!point_ch.ready);
        points_sent++;
        gap = src_idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            point_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold the sender until every predicted result has come back.
    task automatic drain();
        point_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (points_in_flight != 0);
    endtask

    // New random register setting; the registers the kind uses are always
    // rewritten, the others now and then.
    task automatic random_setup();
        kind_t                k;
        int                   r;
        logic [DATA_BITS-1:0] d;
        r = $urandom_range(0, 9);
        if (r < 3)
        begin
            k = KIND_ROTATE;
        end
        else if (r < 5)
        begin
            k = KIND_SCALE;
        end
        else if (r < 7)
        begin
            k = KIND_TRANSLATE;
        end
        else
        begin
            k = kind_t'($urandom_range(KIND_REFLECT_X, KIND_REFLECT_ANTI));
        end
        // junk above the kind field must be ignored
        d = ($urandom_range(0, 3) == 0) ? DATA_BITS'($urandom) : '0;
        d[KIND_BITS-1:0] = k;
        write_reg(REG_KIND, d);
        if (k == KIND_TRANSLATE || k == KIND_SCALE || k == KIND_ROTATE
            || $urandom_range(0, 3) == 0)
        begin
            write_reg(REG_REF_X, rand_ref());
            write_reg(REG_REF_Y, rand_ref());
        end
        if (k == KIND_SCALE || $urandom_range(0, 3) == 0)
        begin
            write_reg(REG_SCALE_X, rand_scale());
            write_reg(REG_SCALE_Y, rand_scale());
        end
        if (k == KIND_ROTATE || $urandom_range(0, 3) == 0)
        begin
            write_reg(REG_ANGLE, rand_angle());
        end
        // unmapped indexes: no register may change
        if ($urandom_range(0, 9) == 0)
        begin
            write_reg(CFG_INDEX_BITS'($urandom_range(REG_ANGLE + 1,
                                                     2 ** CFG_INDEX_BITS - 1)),
                      DATA_BITS'($urandom));
        end
    endtask

    // Result side: ready with random stalls while sink idling is enabled.
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left == 0 && sink_idle_on && $urandom_range(0, 2) == 0)
            begin
                stall_left = pick_gap();
            end
            if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin : stimulus
        int goal;
        int n;
        point_ch.valid   <= 1'b0;
        point_ch.point_x <= '0;
        point_ch.point_y <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= REG_KIND;
        cfg_ch.data      <= '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part ---
        // Reset setting (translate by zero): full-scale corners pass through.
        send_point(COORD_BITS'(-32768), COORD_BITS'(32767));
        send_point(COORD_BITS'(32767), COORD_BITS'(-32768));
        send_point(COORD_BITS'(0), COORD_BITS'(0));
        drain();

        // Translate to the far corner: both coordinates clip, then not.
        write_reg(REG_KIND, DATA_BITS'(KIND_TRANSLATE));
        write_reg(REG_REF_X, DATA_BITS'(32767));
        write_reg(REG_REF_Y, DATA_BITS'(-32768));
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        send_point(COORD_BITS'(1), COORD_BITS'(-1));
        send_point(COORD_BITS'(-32768), COORD_BITS'(32767));
        drain();

        // Scale with factors outside -64..64 (used as raw 8-bit values).
        write_reg(REG_KIND, DATA_BITS'(KIND_SCALE));
        write_reg(REG_REF_X, DATA_BITS'(100));
        write_reg(REG_REF_Y, DATA_BITS'(-200));
        write_reg(REG_SCALE_X, DATA_BITS'(-128));
        write_reg(REG_SCALE_Y, DATA_BITS'(127));
        send_point(COORD_BITS'(32767), COORD_BITS'(-32768));
        send_point(COORD_BITS'(3), COORD_BITS'(5));
        drain();

        // Rotate 45 degrees about an off-origin pivot, overflow at the corner.
        write_reg(REG_KIND, DATA_BITS'(KIND_ROTATE));
        write_reg(REG_REF_X, DATA_BITS'(10));
        write_reg(REG_REF_Y, DATA_BITS'(-10));
        write_reg(REG_ANGLE, DATA_BITS'(45));
        send_point(COORD_BITS'(32767), COORD_BITS'(32767));
        send_point(COORD_BITS'(-32768), COORD_BITS'(0));
        send_point(COORD_BITS'(7), COORD_BITS'(3));
        drain();

        // Angle past 359 wraps modulo 360; pivot at the range extremes.
        write_reg(REG_ANGLE, DATA_BITS'(511));
        write_reg(REG_REF_X, DATA_BITS'(-32768));
        write_reg(REG_REF_Y, DATA_BITS'(32767));
        send_point(COORD_BITS'(100), COORD_BITS'(-100));
        send_point(COORD_BITS'(0), COORD_BITS'(0));
        drain();

        // Every reflection, with the most negative value in each coordinate
        // so that the kinds that negate it saturate.
        for (int k = KIND_REFLECT_X; k <= KIND_REFLECT_ANTI; k++)
        begin
            write_reg(REG_KIND, DATA_BITS'(k));
            send_point(COORD_BITS'(-32768), COORD_BITS'(5));
            send_point(COORD_BITS'(12), COORD_BITS'(-32768));
            drain();
        end

        // --- random part ---
        goal = points_sent + NUM_RANDOM_POINTS;
        while (points_sent < goal)
        begin
            src_idle_on  = ($urandom_range(0, 3) != 0);
            sink_idle_on = ($urandom_range(0, 3) != 0);
            random_setup();
            n = $urandom_range(10, 60);
            for (int i = 0; i < n; i++)
            begin
                send_point(rand_coord(), rand_coord());
                // occasional pause with the pipeline emptied mid-phase
                if ($urandom_range(0, 149) == 0)
                begin
                    drain();
                end
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Hard stop: a lost result or a handshake that never completes.
    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
